@@ sv/tsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

  // Default number of words each stack owns.
  localparam int unsigned TSM_DEPTH = 128;
  localparam int unsigned TSM_NUM_STACKS = 3;

  // Operation codes.
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_PEEK  = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_INVALID  = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         stack_sel;
    logic signed [31:0] push_value;
  } tsm_req_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [1:0]         status;
    logic               is_empty;
  } tsm_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } tsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } tsm_cmd_t;

endpackage

`default_nettype wire

@@ sv/three_stacks_one_memory_unit.sv @@
// Channel  | Ports                      | Handshake
// ---------+----------------------------+-------------------------------------
// request  | start, busy, in_req        | taken on a clock edge with start high
//          |                            | and busy low
// result   | out_valid, out_rsp         | one cycle per result, no backpressure
//
// Each request passes through three steps: accept, one memory access with the count
// update, and the response; a new request is taken only once the last response is out.
// The request register ahead of the memory access and the registered memory
// read behind it account for these steps.
// Reset is synchronous and active low; it clears the three counts, and the
// memory needs no clearing pass. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module three_stacks_one_memory_unit
  import tsm_pkg::*;
#(
  parameter int unsigned DEPTH = TSM_DEPTH
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire tsm_req_t in_req,
  output logic          out_valid,
  output tsm_rsp_t      out_rsp
);

  tsm_cmd_t cmd;

  tsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tsm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

@@ sv/tsm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsm_ctrl
  import tsm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output tsm_cmd_t      cmd
);

  tsm_state_t state_r;
  tsm_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.exec    = 1'b0;
    cmd.respond = 1'b0;
    busy        = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An accepted request is executed in the next cycle.
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("accepted request was not executed");

  // Every response follows an execute cycle.
  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> $past(cmd.exec))
    else $error("response without execute");

endmodule

`default_nettype wire

@@ sv/tsm_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsm_dp
  import tsm_pkg::*;
#(
  parameter int unsigned DEPTH = TSM_DEPTH
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tsm_cmd_t cmd,
  input  wire tsm_req_t in_req,
  output logic          out_valid,
  output tsm_rsp_t      out_rsp
);

  localparam int unsigned WORDS = TSM_NUM_STACKS * DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] BASE1 = AW'(DEPTH);
  localparam logic [AW-1:0] BASE2 = AW'(2 * DEPTH);
  localparam logic [CW-1:0] FULL  = CW'(DEPTH);

  tsm_req_t          req_r;
  logic [CW-1:0]     count_r [TSM_NUM_STACKS];
  logic [31:0]       mem [WORDS];
  logic [31:0]       rd_data_r;
  logic              use_data_r;
  logic [1:0]        status_r;
  logic              empty_r;

  logic              sel_ok;
  logic [1:0]        sel_idx;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_nxt;
  logic [AW-1:0]     base;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              do_write;
  logic              use_data_nxt;
  logic [1:0]        status_nxt;

  // Capture the request when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
  end

  // Decode the request against the selected stack's count.
  always_comb begin
    sel_ok       = (req_r.stack_sel != 2'd3);
    sel_idx      = sel_ok ? req_r.stack_sel : 2'd0;
    cnt          = count_r[sel_idx];
    cnt_nxt      = cnt;
    do_write     = 1'b0;
    use_data_nxt = 1'b0;
    status_nxt   = STATUS_OK;
    case (sel_idx)
      2'd1:    base = BASE1;
      2'd2:    base = BASE2;
      default: base = '0;
    endcase
    wr_addr = base + AW'(cnt);
    rd_addr = base + AW'(cnt) - AW'(1);
    if (!sel_ok) begin
      status_nxt = STATUS_INVALID;
    end else begin
      case (req_r.func)
        FUNC_PUSH: begin
          if (cnt != FULL) begin
            do_write = 1'b1;
            cnt_nxt  = cnt + CW'(1);
          end else begin
            status_nxt = STATUS_OVERFLOW;
          end
        end
        FUNC_POP: begin
          if (cnt == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            cnt_nxt      = cnt - CW'(1);
            use_data_nxt = 1'b1;
          end
        end
        FUNC_PEEK: begin
          if (cnt == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            use_data_nxt = 1'b1;
          end
        end
        default: begin
          if (cnt == '0) begin
            status_nxt = STATUS_EMPTY;
          end
        end
      endcase
    end
  end

  // Occupancy counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TSM_NUM_STACKS; i++) begin
        count_r[i] <= '0;
      end
    end else if (cmd.exec && sel_ok) begin
      count_r[sel_idx] <= cnt_nxt;
    end
  end

  // Shared stack memory: one registered read per request, and one write for an accepted push.
  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      mem[wr_addr] <= req_r.push_value;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Response fields.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      use_data_r <= use_data_nxt;
      status_r   <= status_nxt;
      empty_r    <= sel_ok && (cnt_nxt == '0);
    end
  end

  assign out_valid         = cmd.respond;
  assign out_rsp.read_data = use_data_r ? rd_data_r : 32'sd0;
  assign out_rsp.status    = status_r;
  assign out_rsp.is_empty  = empty_r;

  // No count ever passes the region size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= FULL) && (count_r[1] <= FULL) && (count_r[2] <= FULL))
    else $error("stack count beyond depth");

  // An invalid stack reports zero data and not empty.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == STATUS_INVALID) |->
      (out_rsp.read_data == 32'sd0 && !out_rsp.is_empty))
    else $error("invalid stack response carries data");

  // A push never changes the count by anything but one or zero.
  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sel_ok && req_r.func == FUNC_PUSH) |=>
      (count_r[$past(sel_idx)] == $past(cnt) + CW'(1)
       || count_r[$past(sel_idx)] == $past(cnt)))
    else $error("push moved the count by more than one");

endmodule

`default_nettype wire

@@ dv/three_stacks_one_memory_unit_checker.sv @@
`timescale 1ns / 1ps

module three_stacks_one_memory_unit_checker
  import tsm_pkg::*;
#(
  parameter int unsigned DEPTH = TSM_DEPTH
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  tsm_req_t in_req,
  input  logic     out_valid,
  input  tsm_rsp_t out_rsp,
  output int       mismatches,
  output int       outstanding
);

  // Shadow copy of the three stacks and their fill levels.
  logic [31:0] stack_words [TSM_NUM_STACKS][DEPTH];
  int unsigned fill_level [TSM_NUM_STACKS];

  // Responses predicted for accepted requests, oldest first.
  tsm_rsp_t predicted_rsp_q[$];

  assign outstanding = predicted_rsp_q.size();

  // Applies one request to the shadow stacks and returns the response it must produce.
  function automatic tsm_rsp_t apply_stack_op(input tsm_req_t req);
    tsm_rsp_t    rsp;
    int unsigned fill;
    int unsigned sel;
    rsp = '0;
    sel = 32'(req.stack_sel);
    if (sel >= TSM_NUM_STACKS) begin
      rsp.status = STATUS_INVALID;
    end else begin
      fill = fill_level[sel];
      case (req.func)
        FUNC_PUSH: begin
          if (fill < DEPTH) begin
            stack_words[sel][fill] = req.push_value;
            fill++;
          end else begin
            rsp.status = STATUS_OVERFLOW;
          end
        end
        FUNC_POP: begin
          if (fill == 0) begin
            rsp.status = STATUS_EMPTY;
          end else begin
            fill--;
            rsp.read_data = stack_words[sel][fill];
          end
        end
        FUNC_PEEK: begin
          if (fill == 0) begin
            rsp.status = STATUS_EMPTY;
          end else begin
            rsp.read_data = stack_words[sel][fill - 1];
          end
        end
        default: begin
          if (fill == 0) begin
            rsp.status = STATUS_EMPTY;
          end
        end
      endcase
      fill_level[sel] = fill;
      rsp.is_empty = (fill == 0);
    end
    return rsp;
  endfunction

  // Compare each result with the oldest prediction, then record new requests.
  always @(posedge clk) begin
    tsm_rsp_t want;
    bit       bad;
    if (!rst_n) begin
      predicted_rsp_q.delete();
      for (int s = 0; s < TSM_NUM_STACKS; s++) begin
        fill_level[s] = 0;
      end
      mismatches <= 0;
    end else begin
      if (out_valid) begin
        if (predicted_rsp_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with no request outstanding: data %h status %0d empty %0b",
                     $realtime, out_rsp.read_data, out_rsp.status, out_rsp.is_empty);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = predicted_rsp_q.pop_front();
          bad = (out_rsp.read_data !== want.read_data) || (out_rsp.status !== want.status) ||
                (out_rsp.is_empty !== want.is_empty);
          if (bad) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch: expected data %h status %0d empty %0b,",
                       $realtime, want.read_data, want.status, want.is_empty);
              $display("    got data %h status %0d empty %0b",
                       out_rsp.read_data, out_rsp.status, out_rsp.is_empty);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        predicted_rsp_q.push_back(apply_stack_op(in_req));
      end
    end
  end

endmodule

@@ dv/three_stacks_one_memory_unit_test.sv @@
`timescale 1ns / 1ps

module three_stacks_one_memory_unit_test;
  import tsm_pkg::*;

  localparam int unsigned DEPTH = TSM_DEPTH;
  localparam int ITEMS_PER_PHASE = 667;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] BAD_STACK = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  tsm_req_t in_req = '0;
  logic     busy;
  logic     out_valid;
  tsm_rsp_t out_rsp;
  int       mismatches;
  int       outstanding;
  int       idle_pct = 0;
  int       sent = 0;
  int       quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_stacks_one_memory_unit #(.DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  three_stacks_one_memory_unit_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Ends the run when neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("three_stacks_one_memory_unit verification failed");
        $finish;
      end
    end
  end

  function automatic tsm_req_t stack_req(input logic [1:0] func, input logic [1:0] sel,
                                         input logic [31:0] value);
    tsm_req_t r;
    r.func = func;
    r.stack_sel = sel;
    r.push_value = value;
    return r;
  endfunction

  // Drives one request, with random idle cycles ahead of it, and waits until it is taken.
  task automatic issue(input tsm_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sent++;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // One burst of random traffic: fill a stack past full, drain one past empty, or a short mix.
  task automatic random_burst();
    int          kind;
    int          len;
    int          pick;
    logic [1:0]  sel;
    logic [1:0]  func;
    kind = $urandom_range(0, 9);
    sel = 2'($urandom_range(0, 2));
    if (kind == 0) begin
      len = DEPTH + $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        issue(stack_req(FUNC_PUSH, sel, random_word()));
      end
    end else if (kind == 1) begin
      len = DEPTH + $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        issue(stack_req(FUNC_POP, sel, random_word()));
      end
      issue(stack_req(FUNC_QUERY, sel, random_word()));
    end else begin
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          func = FUNC_PUSH;
        end else if (pick < 70) begin
          func = FUNC_POP;
        end else if (pick < 87) begin
          func = FUNC_PEEK;
        end else begin
          func = FUNC_QUERY;
        end
        sel = ($urandom_range(0, 19) == 0) ? BAD_STACK : 2'($urandom_range(0, 2));
        issue(stack_req(func, sel, random_word()));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty stacks, word extremes, every operation and the invalid stack.
    issue(stack_req(FUNC_QUERY, 2'd0, 32'h0));
    issue(stack_req(FUNC_POP,   2'd0, 32'h0));
    issue(stack_req(FUNC_PEEK,  2'd1, 32'h0));
    issue(stack_req(FUNC_PUSH,  2'd0, 32'h7fff_ffff));
    issue(stack_req(FUNC_PUSH,  2'd0, 32'h8000_0000));
    issue(stack_req(FUNC_PUSH,  2'd1, 32'h0000_0000));
    issue(stack_req(FUNC_PUSH,  2'd2, 32'hffff_ffff));
    issue(stack_req(FUNC_PUSH,  2'd2, 32'h5555_5555));
    issue(stack_req(FUNC_PUSH,  2'd1, 32'haaaa_aaaa));
    issue(stack_req(FUNC_PEEK,  2'd0, 32'h0));
    issue(stack_req(FUNC_QUERY, 2'd0, 32'h0));
    issue(stack_req(FUNC_POP,   2'd0, 32'h0));
    issue(stack_req(FUNC_POP,   2'd0, 32'h0));
    issue(stack_req(FUNC_POP,   2'd0, 32'h0));
    issue(stack_req(FUNC_QUERY, 2'd0, 32'h0));
    issue(stack_req(FUNC_PUSH,  BAD_STACK, 32'h1234_5678));
    issue(stack_req(FUNC_POP,   BAD_STACK, 32'hffff_ffff));
    issue(stack_req(FUNC_PEEK,  BAD_STACK, 32'h0));
    issue(stack_req(FUNC_QUERY, BAD_STACK, 32'h0));
    issue(stack_req(FUNC_POP,   2'd1, 32'h0));
    issue(stack_req(FUNC_PEEK,  2'd2, 32'h0));
    issue(stack_req(FUNC_QUERY, 2'd1, 32'h0));

    // Random traffic in three phases of sender idling.
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 72;
        default: idle_pct = 8;
      endcase
      while (sent < (phase + 1) * ITEMS_PER_PHASE) begin
        random_burst();
      end
    end
    start <= 1'b0;

    // Drain the outstanding responses, then allow a few more cycles for strays.
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("three_stacks_one_memory_unit verification clean");
    end else begin
      $display("three_stacks_one_memory_unit verification failed");
    end
    $finish;
  end

endmodule
